### src/tti_pkg.sv
// Shared types, constants and helpers for the text-to-integer parser.
`timescale 1ns / 1ps

package tti_pkg;

  // Position counting saturates at MAX_CHARS; POS_W covers 0..MAX_CHARS.
  localparam int MAX_CHARS = 4096;
  localparam int POS_W = 13;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

  localparam int FIFO_DEPTH = 2;
  localparam int QW = $clog2(FIFO_DEPTH);

  localparam int ACC_W = 64;
  localparam int BASE_W = 6;
  localparam int MAC_W = ACC_W + BASE_W;

  localparam logic [ACC_W-1:0] ALL_ONES = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] S32_MAX = 64'h0000_0000_7FFF_FFFF;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
  localparam logic [BASE_W-1:0] BASE_BIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_W-1:0] NO_DIGIT = 6'h3F;

  // Result status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_CONV = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_BAD_BASE = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_U64 = 2'd0;
  localparam logic [1:0] KIND_S64 = 2'd1;
  localparam logic [1:0] KIND_S32 = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_IDX_BASE = 1'b0;
  localparam logic CFG_IDX_KIND = 1'b1;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [1:0]  status;
    logic [12:0] end_offset;
  } out_item_t;

  // A classified character as it travels from the front to the core.
  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic              blank;
    logic              plus;
    logic              minus;
    logic              xs;
    logic              bs;
    logic              last;
    logic [POS_W-1:0]  next_pos;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Final parse state of one string, handed to the result formatter.
  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic             neg;
    logic             any_digit;
    logic             ovf;
    logic [POS_W-1:0] dend;
  } fin_t;

  typedef enum logic [5:0] {
    PH_SPACE  = 6'b000001,
    PH_SIGN   = 6'b000010,
    PH_ZERO   = 6'b000100,
    PH_PREFIX = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    base_ok = (b == BASE_AUTO) || ((b >= BASE_MIN) && (b <= BASE_MAX));
  endfunction

endpackage

### src/tti_front.sv
// Front end: accepts characters, classifies them and tracks the position.
`timescale 1ns / 1ps

module tti_front import tti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  in_item_t   in_data,
  output logic       in_stall,
  input  fifo_stat_t q_stat,
  output logic       push,
  output cls_t       push_data
);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_ALPHA_OFS = 8'd10;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic [POS_W-1:0] next_pos;
  logic [7:0]       c;

  function automatic logic [BASE_W-1:0] char_digit(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd0;
    char_digit = NO_DIGIT;
    if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
      v = ch - CH_ZERO;
      char_digit = v[BASE_W-1:0];
    end else if ((ch >= CH_LA) && (ch <= CH_LZ)) begin
      v = ch - CH_LA + CH_ALPHA_OFS;
      char_digit = v[BASE_W-1:0];
    end else if ((ch >= CH_UA) && (ch <= CH_UZ)) begin
      v = ch - CH_UA + CH_ALPHA_OFS;
      char_digit = v[BASE_W-1:0];
    end
  endfunction

  assign c = in_data.char_code;
  assign in_stall = q_stat.full;
  assign push = in_valid && !q_stat.full;
  assign next_pos = (pos_r < POS_MAX) ? pos_r + 1'b1 : POS_MAX;

  always_comb begin
    push_data.digit    = char_digit(c);
    push_data.blank    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                         (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    push_data.plus     = (c == 8'h2B);
    push_data.minus    = (c == 8'h2D);
    push_data.xs       = (c == 8'h78) || (c == 8'h58);
    push_data.bs       = (c == 8'h62) || (c == 8'h42);
    push_data.last     = in_data.is_last;
    push_data.next_pos = next_pos;
  end

  // The count restarts after the last character of a string.
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = in_data.is_last ? '0 : next_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### src/tti_fifo.sv
// Short queue of classified characters between the front and the core.
`timescale 1ns / 1ps

module tti_fifo import tti_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  cls_t       push_data,
  input  logic       pop,
  output cls_t       pop_data,
  output fifo_stat_t stat
);

  cls_t          mem_r [FIFO_DEPTH];
  logic [QW-1:0] wr_ptr_r;
  logic [QW-1:0] wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r;
  logic [QW-1:0] rd_ptr_nxt;
  logic [QW:0]   cnt_r;
  logic [QW:0]   cnt_nxt;

  assign pop_data = mem_r[rd_ptr_r];
  assign stat.full = (cnt_r == (QW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/tti_core.sv
// Parse core: prefix and sign state machine with the digit multiply-add.
`timescale 1ns / 1ps

module tti_core import tti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fifo_stat_t        q_stat,
  input  cls_t              q_data,
  output logic              pop,
  input  logic [BASE_W-1:0] cfg_base,
  output logic              fin_valid,
  output fin_t              fin_data,
  input  logic              fin_take
);

  phase_t            phase_r, phase_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [BASE_W-1:0] eff_r, eff_nxt;
  logic              neg_r, neg_nxt;
  logic              any_r, any_nxt;
  logic              ovf_r, ovf_nxt;
  logic [POS_W-1:0]  dend_r, dend_nxt;
  logic              fin_v_r, fin_v_nxt;
  fin_t              fin_r;
  logic              start;
  logic              try_en;
  logic              digit_ok;
  logic [MAC_W-1:0]  mac;
  logic              fin_load;

  // A last character waits until the formatter has room for its result.
  assign pop = !q_stat.empty && (!q_data.last || !fin_v_r || fin_take);
  assign fin_load = pop && q_data.last;
  assign fin_valid = fin_v_r;
  assign fin_data = fin_r;

  assign mac = ({{BASE_W{1'b0}}, acc_r} * {{ACC_W{1'b0}}, eff_nxt}) +
               {{ACC_W{1'b0}}, q_data.digit};
  assign digit_ok = (eff_nxt >= BASE_MIN) && (eff_nxt <= BASE_MAX) &&
                    (q_data.digit < eff_nxt);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    eff_nxt = eff_r;
    neg_nxt = neg_r;
    any_nxt = any_r;
    ovf_nxt = ovf_r;
    dend_nxt = dend_r;
    start = 1'b0;
    try_en = 1'b0;
    case (phase_r)
      PH_SPACE: begin
        if (!q_data.blank) begin
          if (q_data.plus || q_data.minus) begin
            neg_nxt = q_data.minus;
            phase_nxt = PH_SIGN;
          end else begin
            start = 1'b1;
          end
        end
      end
      PH_SIGN: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (eff_r == BASE_AUTO) begin
          if (q_data.xs) begin
            eff_nxt = BASE_HEX;
            phase_nxt = PH_PREFIX;
          end else if (q_data.bs) begin
            eff_nxt = BASE_BIN;
            phase_nxt = PH_PREFIX;
          end else begin
            eff_nxt = BASE_OCT;
            try_en = 1'b1;
          end
        end else if (((eff_r == BASE_HEX) && q_data.xs) ||
                     ((eff_r == BASE_BIN) && q_data.bs)) begin
          phase_nxt = PH_PREFIX;
        end else begin
          try_en = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        try_en = 1'b1;
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    // First character after blanks and sign: latch the radix.
    if (start) begin
      if (!base_ok(cfg_base)) begin
        phase_nxt = PH_DONE;
      end else if ((q_data.digit == 6'd0) &&
                   ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX) ||
                    (cfg_base == BASE_BIN))) begin
        // A leading zero may open a prefix; it already counts as a digit.
        eff_nxt = cfg_base;
        any_nxt = 1'b1;
        acc_nxt = '0;
        dend_nxt = q_data.next_pos;
        phase_nxt = PH_ZERO;
      end else begin
        eff_nxt = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
        try_en = 1'b1;
      end
    end

    if (try_en) begin
      if (digit_ok) begin
        any_nxt = 1'b1;
        dend_nxt = q_data.next_pos;
        if (!ovf_r) begin
          if (|mac[MAC_W-1:ACC_W]) begin
            ovf_nxt = 1'b1;
            acc_nxt = ALL_ONES;
          end else begin
            acc_nxt = mac[ACC_W-1:0];
          end
        end
        phase_nxt = PH_DIGITS;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  always_comb begin
    fin_v_nxt = fin_v_r;
    if (fin_load) begin
      fin_v_nxt = 1'b1;
    end else if (fin_take) begin
      fin_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_r.acc <= acc_nxt;
      fin_r.neg <= neg_nxt;
      fin_r.any_digit <= any_nxt;
      fin_r.ovf <= ovf_nxt;
      fin_r.dend <= dend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      acc_r <= '0;
      eff_r <= BASE_AUTO;
      neg_r <= 1'b0;
      any_r <= 1'b0;
      ovf_r <= 1'b0;
      dend_r <= '0;
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= fin_v_nxt;
      if (fin_load) begin
        // The string is finished; start over for the next one.
        phase_r <= PH_SPACE;
        acc_r <= '0;
        eff_r <= BASE_AUTO;
        neg_r <= 1'b0;
        any_r <= 1'b0;
        ovf_r <= 1'b0;
        dend_r <= '0;
      end else if (pop) begin
        phase_r <= phase_nxt;
        acc_r <= acc_nxt;
        eff_r <= eff_nxt;
        neg_r <= neg_nxt;
        any_r <= any_nxt;
        ovf_r <= ovf_nxt;
        dend_r <= dend_nxt;
      end
    end
  end

endmodule

### src/tti_fmt.sv
// Result formatter: sign, clamping and status, into the output register.
`timescale 1ns / 1ps

module tti_fmt import tti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fin_valid,
  input  fin_t              fin_data,
  output logic              fin_take,
  input  logic [BASE_W-1:0] cfg_base,
  input  logic [1:0]        cfg_kind,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              out_stall
);

  logic             out_valid_r;
  out_item_t        out_r;
  out_item_t        res;
  logic [ACC_W-1:0] pmax;
  logic [ACC_W-1:0] pmin_mag;

  assign fin_take = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  assign pmax = (cfg_kind == KIND_S32) ? S32_MAX : S64_MAX;
  assign pmin_mag = pmax + 1'b1;

  always_comb begin
    res.value_bits = '0;
    res.status = ST_OK;
    res.end_offset = '0;
    if (!base_ok(cfg_base)) begin
      res.status = ST_BAD_BASE;
    end else if (!fin_data.any_digit) begin
      res.status = ST_NO_CONV;
    end else begin
      res.end_offset = fin_data.dend[12:0];
      if (cfg_kind == KIND_U64) begin
        if (fin_data.ovf) begin
          res.value_bits = ALL_ONES;
          res.status = ST_RANGE;
        end else begin
          res.value_bits = fin_data.neg ? ('0 - fin_data.acc) : fin_data.acc;
        end
      end else if (fin_data.neg) begin
        if (fin_data.ovf || (fin_data.acc > pmin_mag)) begin
          res.value_bits = '0 - pmin_mag;
          res.status = ST_RANGE;
        end else begin
          res.value_bits = '0 - fin_data.acc;
        end
      end else begin
        if (fin_data.ovf || (fin_data.acc > pmax)) begin
          res.value_bits = pmax;
          res.status = ST_RANGE;
        end else begin
          res.value_bits = fin_data.acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take && fin_valid) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_take) begin
      out_valid_r <= fin_valid;
    end
  end

endmodule

### src/text_to_integer_parser_top.sv
// Streaming string-to-integer converter, top level.
//
// Characters arrive one per transfer on the in_ channel; is_last marks the
// final character of a string. One result per string leaves on the out_
// channel: value, status and the count of characters consumed.
// Throughput is one character per cycle while in_stall is low. The result of
// a string passes through the classifier queue, the core's result register
// after the digit multiply-add, and the output register of the formatting
// stage that negates and clamps, before it appears on out_valid.
// The two configuration registers (radix and result kind) are written through
// cfg_we, cfg_index and cfg_wdata and are read live by the core and the formatter.
// While the receiver stalls, the output register holds its result; the next
// finished string waits in the core's result register, the two-entry queue fills,
// and in_stall rises once it is full.
// Reset clears both registers, the parse state and all valid flags.
`timescale 1ns / 1ps

module text_to_integer_parser_top import tti_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              in_stall,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              out_stall,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_wdata
);

  logic [BASE_W-1:0] number_base_r;
  logic [1:0]        result_kind_r;
  fifo_stat_t        q_stat;
  logic              push;
  cls_t              push_data;
  logic              pop;
  cls_t              pop_data;
  logic              fin_valid;
  fin_t              fin_data;
  logic              fin_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
      result_kind_r <= KIND_U64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_BASE: number_base_r <= cfg_wdata;
        CFG_IDX_KIND: result_kind_r <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  tti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  tti_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  tti_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .pop       (pop),
    .cfg_base  (number_base_r),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_take  (fin_take)
  );

  tti_fmt u_fmt (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_take  (fin_take),
    .cfg_base  (number_base_r),
    .cfg_kind  (result_kind_r),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // A failed conversion never reports a value or a consumed length.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_data.status == ST_NO_CONV) || (out_data.status == ST_BAD_BASE))
    |-> (out_data.value_bits == '0) && (out_data.end_offset == '0))
    else $error("failed conversion with nonzero value or offset");

  // The queue only fills when the core was blocked by a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a stalled result");

  // Results of the 32-bit kind are always sign-extended.
  a_s32_ext: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (result_kind_r == KIND_S32)
    |-> (out_data.value_bits[63:31] == '0) || (&out_data.value_bits[63:31]))
    else $error("32-bit result not sign-extended");

endmodule
